### sv/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

### sv/fsmc_pkg.sv
package fsmc_pkg;

    // fixed geometry
    localparam int BANK_BYTES   = 65536;
    localparam int SECTOR_BYTES = 4096;
    localparam int SECTOR_SH    = $clog2(SECTOR_BYTES);

    // widths that cover the largest supported part
    localparam int IDX_W = 17;
    localparam int LEN_W = 18;

    // request queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // back-end operations
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_ID    = 2'd1;
    localparam logic [1:0] OP_PROG  = 2'd2;
    localparam logic [1:0] OP_ERASE = 2'd3;

    // command bus addresses and bytes
    localparam logic [15:0] ADDR_UNLOCK1 = 16'h5555;
    localparam logic [15:0] ADDR_UNLOCK2 = 16'h2AAA;
    localparam logic [7:0]  CMD_UNLOCK1      = 8'hAA;
    localparam logic [7:0]  CMD_UNLOCK2      = 8'h55;
    localparam logic [7:0]  CMD_ID_ENTER     = 8'h90;
    localparam logic [7:0]  CMD_ID_EXIT      = 8'hF0;
    localparam logic [7:0]  CMD_ERASE_ARM    = 8'h80;
    localparam logic [7:0]  CMD_CHIP_ERASE   = 8'h10;
    localparam logic [7:0]  CMD_SECTOR_ERASE = 8'h30;
    localparam logic [7:0]  CMD_PROGRAM      = 8'hA0;
    localparam logic [7:0]  CMD_BANK         = 8'hB0;

    // identification bytes
    localparam logic [7:0] ID0_SMALL = 8'h32;
    localparam logic [7:0] ID1_SMALL = 8'h1B;
    localparam logic [7:0] ID0_LARGE = 8'h62;
    localparam logic [7:0] ID1_LARGE = 8'h13;

    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data;
        logic [LEN_W-1:0] len;
    } t_op;

    typedef struct packed {
        logic init_busy;
    } t_back_status;

endpackage

### sv/flash_save_memory_command_fsm.sv
// Channel  | Dir | Handshake                    | Payload
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | tuser: kind; tdata: address, wdata
// m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: rdata
// cfg      | in  | i_cfg_valid/o_cfg_ready      | i_cfg_data: large_device
//
// Reads, programs and command writes are taken one per cycle while s_axis_tready is high;
// a read's byte passes the queue, the registered array read and then the output register.
// After reset the array is cleared to 0xFF, all MEM_BYTES bytes; s_axis_tready stays low.
// A sector erase holds the array write port while it clears 4096 bytes, a chip erase while
// it clears 65536 (64 KB part) or MEM_BYTES bytes (128 KB part); requests wait in the
// 4-entry queue meanwhile, the input stalls once it is full, output stalls back into it.
module flash_save_memory_command_fsm #(
    parameter int MEM_BYTES = 131072
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_data,     // [0] large_device
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] address, [23:16] wdata
    input  logic [0:0]  s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [7:0] rdata
);

    fsmc_pkg::t_back_status status;
    fsmc_pkg::t_op          push_op;
    fsmc_pkg::t_op          head_op;
    logic                   push;
    logic                   q_full;
    logic                   q_valid;
    logic                   pop;

    fsmc_front #(
        .MEM_BYTES (MEM_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_kind      (s_axis_tuser[0]),
        .i_address   (s_axis_tdata[15:0]),
        .i_wdata     (s_axis_tdata[23:16]),
        .i_status    (status),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_op        (push_op)
    );

    fsmc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (head_op),
        .i_pop   (pop)
    );

    fsmc_back #(
        .MEM_BYTES (MEM_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_op    (head_op),
        .o_pop     (pop),
        .o_status  (status),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_rdata   (m_axis_tdata)
    );

endmodule

### sv/fsmc_front.sv
module fsmc_front #(
    parameter int MEM_BYTES = 131072
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [0:0]              i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_kind,
    input  logic [15:0]             i_address,
    input  logic [7:0]              i_wdata,
    input  fsmc_pkg::t_back_status  i_status,
    input  logic                    i_q_full,
    output logic                    o_push,
    output fsmc_pkg::t_op           o_op
);

    localparam logic [2:0] PH_READY   = 3'd0;
    localparam logic [2:0] PH_UNLOCK1 = 3'd1;
    localparam logic [2:0] PH_UNLOCK2 = 3'd2;
    localparam logic [2:0] PH_PROGRAM = 3'd3;
    localparam logic [2:0] PH_BANK    = 3'd4;

    localparam int LW = fsmc_pkg::LEN_W;
    localparam int IW = fsmc_pkg::IDX_W;
    localparam logic [LW-1:0] MEM_SIZE  = LW'(MEM_BYTES);
    localparam logic [LW-1:0] LEN_SMALL = LW'(fsmc_pkg::BANK_BYTES);
    localparam logic [LW-1:0] LEN_LARGE = LW'((2 * fsmc_pkg::BANK_BYTES > MEM_BYTES) ?
                                              MEM_BYTES : 2 * fsmc_pkg::BANK_BYTES);
    localparam logic [LW-1:0] LEN_SECTOR = LW'(fsmc_pkg::SECTOR_BYTES);

    logic [2:0] r_phase, n_phase;
    logic       r_armed, n_armed;
    logic       r_id, n_id;
    logic       r_bank, n_bank;
    logic       r_large;
    logic       accept;
    logic       eff_bank;
    logic       c2;
    logic [15:0] sector_base;

    // bank offset plus address, wrapped at the array size
    function automatic logic [IW-1:0] f_cell(input logic bank, input logic [15:0] base);
        logic [LW-1:0] sum;
        sum = {1'b0, bank, base};
        if (sum >= MEM_SIZE) begin
            sum = sum - MEM_SIZE;
        end
        return sum[IW-1:0];
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !i_status.init_busy && !i_q_full;
    assign accept      = i_valid && o_ready;
    assign eff_bank    = r_bank && r_large;
    assign c2          = (r_phase == PH_UNLOCK2);
    assign sector_base = (i_address >> fsmc_pkg::SECTOR_SH) << fsmc_pkg::SECTOR_SH;

    // command decode
    always_comb begin
        n_phase = r_phase;
        n_armed = r_armed;
        n_id    = r_id;
        n_bank  = r_bank;
        o_push  = 1'b0;
        o_op.op   = fsmc_pkg::OP_READ;
        o_op.idx  = f_cell(eff_bank, i_address);
        o_op.data = i_wdata;
        o_op.len  = '0;
        if (accept) begin
            if (!i_kind) begin
                o_push = 1'b1;
                if (r_id && i_address == 16'd0) begin
                    o_op.op   = fsmc_pkg::OP_ID;
                    o_op.data = r_large ? fsmc_pkg::ID0_LARGE : fsmc_pkg::ID0_SMALL;
                end else if (r_id && i_address == 16'd1) begin
                    o_op.op   = fsmc_pkg::OP_ID;
                    o_op.data = r_large ? fsmc_pkg::ID1_LARGE : fsmc_pkg::ID1_SMALL;
                end
            end else if (r_phase == PH_PROGRAM) begin
                o_push  = 1'b1;
                o_op.op = fsmc_pkg::OP_PROG;
                n_phase = PH_READY;
            end else if (r_armed && i_wdata == fsmc_pkg::CMD_SECTOR_ERASE) begin
                o_push   = 1'b1;
                o_op.op  = fsmc_pkg::OP_ERASE;
                o_op.idx = f_cell(eff_bank, sector_base);
                o_op.len = LEN_SECTOR;
                n_armed  = 1'b0;
                n_phase  = PH_READY;
            end else if (r_phase == PH_BANK && i_address == 16'd0) begin
                n_bank  = (i_wdata != 8'd0);
                n_phase = PH_READY;
            end else if (i_address == fsmc_pkg::ADDR_UNLOCK1) begin
                unique case (i_wdata)
                    fsmc_pkg::CMD_UNLOCK1: begin
                        if (r_phase == PH_READY) n_phase = PH_UNLOCK1;
                    end
                    fsmc_pkg::CMD_ID_ENTER: begin
                        if (c2) begin
                            n_id    = 1'b1;
                            n_phase = PH_READY;
                        end
                    end
                    fsmc_pkg::CMD_ID_EXIT: begin
                        if (c2) begin
                            n_id    = 1'b0;
                            n_phase = PH_READY;
                        end
                    end
                    fsmc_pkg::CMD_ERASE_ARM: begin
                        if (c2) begin
                            n_armed = 1'b1;
                            n_phase = PH_READY;
                        end
                    end
                    fsmc_pkg::CMD_CHIP_ERASE: begin
                        if (c2 && r_armed) begin
                            o_push   = 1'b1;
                            o_op.op  = fsmc_pkg::OP_ERASE;
                            o_op.idx = '0;
                            o_op.len = r_large ? LEN_LARGE : LEN_SMALL;
                            n_armed  = 1'b0;
                            n_phase  = PH_READY;
                        end
                    end
                    fsmc_pkg::CMD_SECTOR_ERASE: begin
                        if (c2 && r_armed) n_phase = PH_READY;
                    end
                    fsmc_pkg::CMD_PROGRAM: begin
                        if (c2) n_phase = PH_PROGRAM;
                    end
                    fsmc_pkg::CMD_BANK: begin
                        if (c2 && r_large) n_phase = PH_BANK;
                    end
                    default: begin
                        n_phase = PH_READY;
                    end
                endcase
            end else if (i_address == fsmc_pkg::ADDR_UNLOCK2) begin
                if (i_wdata == fsmc_pkg::CMD_UNLOCK2 && r_phase == PH_UNLOCK1) begin
                    n_phase = PH_UNLOCK2;
                end
            end
        end
    end

    // command state and device size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_READY;
            r_armed <= 1'b0;
            r_id    <= 1'b0;
            r_bank  <= 1'b0;
            r_large <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_armed <= n_armed;
            r_id    <= n_id;
            r_bank  <= n_bank;
            if (i_cfg_valid) r_large <= i_cfg_data[0];
        end
    end

endmodule

### sv/fsmc_queue.sv
module fsmc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fsmc_pkg::t_op i_op,
    output logic          o_full,
    output logic          o_valid,
    output fsmc_pkg::t_op o_op,
    input  logic          i_pop
);

    localparam int PW = fsmc_pkg::Q_PTR_W;
    localparam int CW = fsmc_pkg::Q_CNT_W;

    fsmc_pkg::t_op r_slot [fsmc_pkg::Q_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(fsmc_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_slot[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr_ptr] <= i_op;
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + PW'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + PW'(1);
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

### sv/fsmc_back.sv
`include "assert_macros.svh"

module fsmc_back #(
    parameter int MEM_BYTES = 131072
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  fsmc_pkg::t_op          i_q_op,
    output logic                   o_pop,
    output fsmc_pkg::t_back_status o_status,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [7:0]             o_rdata
);

    localparam int AW = $clog2(MEM_BYTES);
    localparam int LW = $clog2(MEM_BYTES + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(MEM_BYTES - 1);

    logic [7:0]    r_array [MEM_BYTES];
    logic [7:0]    r_mem_q;
    logic          r_init;
    logic          r_sweep;
    logic [AW-1:0] r_ptr;
    logic [LW-1:0] r_left;
    logic          r_rd_pend;
    logic          r_pend_id;
    logic [7:0]    r_pend_byte;
    logic          r_out_v;
    logic [7:0]    r_out_d;

    logic          out_free;
    logic          head_is_rd;
    logic          advance;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;

    assign out_free   = !r_out_v || i_ready;
    assign advance    = r_rd_pend && out_free;
    assign head_is_rd = (i_q_op.op == fsmc_pkg::OP_READ) || (i_q_op.op == fsmc_pkg::OP_ID);
    assign o_pop      = i_q_valid && !r_sweep && (!head_is_rd || !r_rd_pend || out_free);
    assign mem_re     = o_pop && (i_q_op.op == fsmc_pkg::OP_READ);
    assign mem_we     = r_sweep || (o_pop && i_q_op.op == fsmc_pkg::OP_PROG);
    assign waddr      = r_sweep ? r_ptr : i_q_op.idx[AW-1:0];
    assign wdata      = r_sweep ? fsmc_pkg::ERASED_BYTE : i_q_op.data;

    assign o_status.init_busy = r_init;
    assign o_valid = r_out_v;
    assign o_rdata = r_out_d;

    // byte array, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) r_array[waddr] <= wdata;
        if (mem_re) r_mem_q <= r_array[i_q_op.idx[AW-1:0]];
    end

    // erase sweep: reset clearing pass, sector and chip erase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init  <= 1'b1;
            r_sweep <= 1'b1;
            r_ptr   <= '0;
            r_left  <= LW'(MEM_BYTES);
        end else if (r_sweep) begin
            r_ptr  <= (r_ptr == LAST_IDX) ? '0 : r_ptr + AW'(1);
            r_left <= r_left - LW'(1);
            if (r_left == LW'(1)) begin
                r_sweep <= 1'b0;
                r_init  <= 1'b0;
            end
        end else if (o_pop && i_q_op.op == fsmc_pkg::OP_ERASE) begin
            r_sweep <= 1'b1;
            r_ptr   <= i_q_op.idx[AW-1:0];
            r_left  <= i_q_op.len[LW-1:0];
        end
    end

    // read in flight and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            if (o_pop && head_is_rd) begin
                r_rd_pend <= 1'b1;
            end else if (advance) begin
                r_rd_pend <= 1'b0;
            end
            if (advance) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // read payload
    always_ff @(posedge i_clk) begin
        if (o_pop && head_is_rd) begin
            r_pend_id   <= (i_q_op.op == fsmc_pkg::OP_ID);
            r_pend_byte <= i_q_op.data;
        end
        if (advance) r_out_d <= r_pend_id ? r_pend_byte : r_mem_q;
    end

    `ASSERT_NEVER(a_no_pop_in_sweep, i_clk, i_rst_n, r_sweep && o_pop, "request taken during erase sweep")
    `ASSERT_NEVER(a_sweep_count, i_clk, i_rst_n, r_sweep && r_left == '0, "sweep running with zero count")
    `ASSERT_NEVER(a_sweep_ptr, i_clk, i_rst_n, r_sweep && r_ptr > LAST_IDX, "sweep pointer past array")
    `ASSERT_CLK(a_pend_held, i_clk, i_rst_n, r_rd_pend && !out_free |=> r_rd_pend && $stable(r_mem_q), "stalled read lost")

endmodule

### tb/tb_flash_save_memory_command_fsm.sv
`timescale 1ns / 1ps

module tb_flash_save_memory_command_fsm;

    localparam int MEM_BYTES   = 131072;
    // init sweep + three worst-case chip erases + sector erase budget + traffic, several times over
    localparam int RUN_LIMIT   = 3_000_000;
    localparam int HOLD_CYCLES = 400;

    // command decoder phases
    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_GOT_AA    = 3'd1,
        PH_GOT_55    = 3'd2,
        PH_PROG_NEXT = 3'd3,
        PH_BANK_NEXT = 3'd4
    } t_cmd_phase;

    typedef enum logic [1:0] {
        EFF_NONE,
        EFF_PROGRAM,
        EFF_SECTOR_ERASE,
        EFF_CHIP_ERASE
    } t_mem_effect;

    typedef struct packed {
        t_cmd_phase phase;
        logic       armed;
        logic       id_on;
        logic       bank1;
    } t_flash_ctl;

    typedef struct packed {
        logic        wr;
        logic [15:0] addr;
        logic [7:0]  data;
    } t_bus_req;

    localparam t_flash_ctl CTL_RESET = '{PH_IDLE, 1'b0, 1'b0, 1'b0};

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_data    = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;    // [15:0] address, [23:16] wdata
    logic [0:0]  s_axis_tuser  = 1'b0;  // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [7:0] rdata

    flash_save_memory_command_fsm #(
        .MEM_BYTES(MEM_BYTES)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // predicted device contents and control state
    logic [7:0]  flash_mem [0:MEM_BYTES-1];
    t_flash_ctl  pred_ctl;
    logic        pred_big = 1'b0;
    logic [7:0]  rdata_expect [$];

    // stimulus side: pending requests and a control-only shadow used to budget erases
    t_bus_req    req_q [$];
    logic        cfg_q [$];
    t_flash_ctl  gen_ctl;
    logic        gen_big = 1'b0;
    int          req_total = 0;
    int          sector_budget = 24;
    int          chip_budget = 3;
    logic [15:0] hot_addr [8];

    int          send_idle_pct = 0;
    int          stall_pct = 0;
    logic        hold_trig = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;
    int          err_cnt = 0;
    int          cyc_cnt = 0;
    t_bus_req    nxt_req;
    logic [7:0]  want_rdata;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        err_cnt++;
    endtask

    // control-state transition of one write; also says what it does to the array
    function automatic t_flash_ctl next_cmd_state(input t_flash_ctl s, input logic [15:0] a,
                                                  input logic [7:0] d, input logic big,
                                                  output t_mem_effect eff);
        t_flash_ctl n;
        logic       at_cmd;
        n      = s;
        eff    = EFF_NONE;
        at_cmd = (s.phase == PH_GOT_55);
        if (s.phase == PH_PROG_NEXT) begin
            eff     = EFF_PROGRAM;
            n.phase = PH_IDLE;
        end else if (s.armed && d == fsmc_pkg::CMD_SECTOR_ERASE) begin
            eff     = EFF_SECTOR_ERASE;
            n.armed = 1'b0;
            n.phase = PH_IDLE;
        end else if (s.phase == PH_BANK_NEXT && a == 16'h0000) begin
            n.bank1 = (d != 8'h00);
            n.phase = PH_IDLE;
        end else if (a == fsmc_pkg::ADDR_UNLOCK1) begin
            case (d)
                fsmc_pkg::CMD_UNLOCK1: begin
                    if (s.phase == PH_IDLE) n.phase = PH_GOT_AA;
                end
                fsmc_pkg::CMD_ID_ENTER: begin
                    if (at_cmd) begin
                        n.id_on = 1'b1;
                        n.phase = PH_IDLE;
                    end
                end
                fsmc_pkg::CMD_ID_EXIT: begin
                    if (at_cmd) begin
                        n.id_on = 1'b0;
                        n.phase = PH_IDLE;
                    end
                end
                fsmc_pkg::CMD_ERASE_ARM: begin
                    if (at_cmd) begin
                        n.armed = 1'b1;
                        n.phase = PH_IDLE;
                    end
                end
                fsmc_pkg::CMD_CHIP_ERASE: begin
                    if (at_cmd && s.armed) begin
                        eff     = EFF_CHIP_ERASE;
                        n.armed = 1'b0;
                        n.phase = PH_IDLE;
                    end
                end
                // armed case is taken above; unarmed it is ignored
                fsmc_pkg::CMD_SECTOR_ERASE: begin
                end
                fsmc_pkg::CMD_PROGRAM: begin
                    if (at_cmd) n.phase = PH_PROG_NEXT;
                end
                fsmc_pkg::CMD_BANK: begin
                    if (at_cmd && big) n.phase = PH_BANK_NEXT;
                end
                default: begin
                    n.phase = PH_IDLE;
                end
            endcase
        end else if (a == fsmc_pkg::ADDR_UNLOCK2) begin
            if (d == fsmc_pkg::CMD_UNLOCK2 && s.phase == PH_GOT_AA) n.phase = PH_GOT_55;
        end
        return n;
    endfunction

    // update the predicted device for one accepted request
    task automatic track_bus_req(input logic wr, input logic [15:0] a, input logic [7:0] d);
        t_mem_effect eff;
        t_flash_ctl  nxt;
        logic [16:0] base;
        logic [16:0] idx;
        int          span;
        base = {pred_ctl.bank1 & pred_big, 16'h0000};
        if (!wr) begin
            if (pred_ctl.id_on && a == 16'h0000)
                rdata_expect.push_back(pred_big ? fsmc_pkg::ID0_LARGE : fsmc_pkg::ID0_SMALL);
            else if (pred_ctl.id_on && a == 16'h0001)
                rdata_expect.push_back(pred_big ? fsmc_pkg::ID1_LARGE : fsmc_pkg::ID1_SMALL);
            else begin
                idx = base + {1'b0, a};
                rdata_expect.push_back(flash_mem[idx]);
            end
        end else begin
            nxt = next_cmd_state(pred_ctl, a, d, pred_big, eff);
            case (eff)
                EFF_PROGRAM: begin
                    idx = base + {1'b0, a};
                    flash_mem[idx] = d;
                end
                EFF_SECTOR_ERASE: begin
                    for (int i = 0; i < fsmc_pkg::SECTOR_BYTES; i++) begin
                        idx = base + {1'b0, a[15:12], 12'h000} + 17'(i);
                        flash_mem[idx] = fsmc_pkg::ERASED_BYTE;
                    end
                end
                EFF_CHIP_ERASE: begin
                    span = pred_big ? 2 * fsmc_pkg::BANK_BYTES : fsmc_pkg::BANK_BYTES;
                    if (span > MEM_BYTES) span = MEM_BYTES;
                    for (int i = 0; i < span; i++) flash_mem[i] = fsmc_pkg::ERASED_BYTE;
                end
                default: begin
                end
            endcase
            pred_ctl = nxt;
        end
    endtask

    // queue one request; erases beyond the erase budget get their data bent off by one bit
    task automatic push_req(input logic wr, input logic [15:0] a, input logic [7:0] d);
        t_mem_effect eff;
        t_flash_ctl  nxt;
        logic [7:0]  dv;
        dv = d;
        if (wr) begin
            nxt = next_cmd_state(gen_ctl, a, dv, gen_big, eff);
            if ((eff == EFF_SECTOR_ERASE && sector_budget == 0) ||
                (eff == EFF_CHIP_ERASE && chip_budget == 0)) begin
                dv  = dv ^ 8'h01;
                nxt = next_cmd_state(gen_ctl, a, dv, gen_big, eff);
            end
            if (eff == EFF_SECTOR_ERASE) sector_budget--;
            if (eff == EFF_CHIP_ERASE) chip_budget--;
            gen_ctl = nxt;
        end
        req_q.push_back('{wr, a, dv});
        req_total++;
    endtask

    // unlock sequence followed by a command byte
    task automatic send_cmd(input logic [7:0] cmd);
        push_req(1'b1, fsmc_pkg::ADDR_UNLOCK1, fsmc_pkg::CMD_UNLOCK1);
        push_req(1'b1, fsmc_pkg::ADDR_UNLOCK2, fsmc_pkg::CMD_UNLOCK2);
        push_req(1'b1, fsmc_pkg::ADDR_UNLOCK1, cmd);
    endtask

    task automatic gen_random(input int n);
        int          stop;
        int          pick;
        logic [15:0] a;
        hot_addr[0] = 16'h0000;
        hot_addr[1] = 16'h0001;
        hot_addr[2] = fsmc_pkg::ADDR_UNLOCK1;
        hot_addr[3] = fsmc_pkg::ADDR_UNLOCK2;
        hot_addr[4] = 16'hFFFF;
        for (int i = 5; i < 8; i++) hot_addr[i] = 16'($urandom);
        stop = req_total + n;
        while (req_total < stop) begin
            pick = $urandom_range(99);
            a = ($urandom_range(9) < 7) ? hot_addr[3'($urandom_range(7))] : 16'($urandom);
            if (pick < 30) begin
                if (gen_ctl.id_on && $urandom_range(3) == 0) a = 16'($urandom_range(1));
                push_req(1'b0, a, 8'($urandom));
            end else if (pick < 48) begin
                send_cmd(fsmc_pkg::CMD_PROGRAM);
                push_req(1'b1, a, 8'($urandom));
            end else if (pick < 56) begin
                send_cmd($urandom_range(1) ? fsmc_pkg::CMD_ID_ENTER : fsmc_pkg::CMD_ID_EXIT);
            end else if (pick < 63) begin
                send_cmd(fsmc_pkg::CMD_ERASE_ARM);
            end else if (pick < 67) begin
                push_req(1'b1, a, fsmc_pkg::CMD_SECTOR_ERASE);
            end else if (pick < 70) begin
                send_cmd(fsmc_pkg::CMD_CHIP_ERASE);
            end else if (pick < 76) begin
                send_cmd(fsmc_pkg::CMD_BANK);
                push_req(1'b1, ($urandom_range(3) == 0) ? a : 16'h0000,
                         $urandom_range(1) ? 8'h00 : 8'($urandom));
            end else if (pick < 80) begin
                send_cmd(fsmc_pkg::CMD_SECTOR_ERASE);
            end else if (pick < 90) begin
                // broken or partial unlock
                push_req(1'b1, fsmc_pkg::ADDR_UNLOCK1, fsmc_pkg::CMD_UNLOCK1);
                if ($urandom_range(1))
                    push_req(1'b1, fsmc_pkg::ADDR_UNLOCK2,
                             $urandom_range(1) ? fsmc_pkg::CMD_UNLOCK2 : 8'($urandom));
                push_req(1'b1, $urandom_range(1) ? fsmc_pkg::ADDR_UNLOCK1 : 16'($urandom),
                         8'($urandom));
            end else begin
                push_req(1'b1, $urandom_range(1) ? a : 16'($urandom), 8'($urandom));
            end
        end
    endtask

    // a trailing read only returns once any erase ahead of it has finished
    task automatic wait_drained();
        push_req(1'b0, 16'($urandom), 8'($urandom));
        while (req_q.size() != 0 || s_axis_tvalid || rdata_expect.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_part(input logic big);
        cfg_q.push_back(big);
        gen_big = big;
        @(negedge i_clk);
        while (cfg_q.size() != 0 || i_cfg_valid) @(negedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                track_bus_req(s_axis_tuser[0], s_axis_tdata[15:0], s_axis_tdata[23:16]);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt_req = req_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {nxt_req.data, nxt_req.addr};
                    s_axis_tuser  <= nxt_req.wr;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // read data monitor and output back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (rdata_expect.size() == 0) begin
                    report_mismatch($sformatf("unexpected rdata %02h", m_axis_tdata));
                end else begin
                    want_rdata = rdata_expect.pop_front();
                    if (m_axis_tdata !== want_rdata)
                        report_mismatch($sformatf("rdata got %02h expected %02h",
                                                  m_axis_tdata, want_rdata));
                end
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
        end
    end

    // long receiver hold-off, started by a toggle
    always @(posedge i_clk) begin
        if (hold_seen != hold_trig) begin
            hold_seen <= hold_trig;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // configuration writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            pred_big = i_cfg_data[0];
            i_cfg_valid <= 1'b0;
        end else if (!i_cfg_valid && cfg_q.size() != 0) begin
            i_cfg_data  <= cfg_q.pop_front();
            i_cfg_valid <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt == RUN_LIMIT) begin
            $display("FAIL flash_save_memory_command_fsm");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < MEM_BYTES; i++) flash_mem[i] = fsmc_pkg::ERASED_BYTE;
        pred_ctl = CTL_RESET;
        gen_ctl  = CTL_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, 64 KB part: program, sector erase, chip erase
        set_part(1'b0);
        set_idling(0, 0);
        push_req(1'b0, 16'hFFFF, 8'hFF);
        send_cmd(fsmc_pkg::CMD_PROGRAM);
        push_req(1'b1, 16'h0000, 8'h00);
        push_req(1'b0, 16'h0000, 8'h00);
        send_cmd(fsmc_pkg::CMD_ERASE_ARM);
        push_req(1'b1, 16'h0ABC, fsmc_pkg::CMD_SECTOR_ERASE);
        push_req(1'b0, 16'h0000, 8'h00);
        send_cmd(fsmc_pkg::CMD_PROGRAM);
        push_req(1'b1, 16'hFFFF, 8'h5A);
        send_cmd(fsmc_pkg::CMD_ERASE_ARM);
        send_cmd(fsmc_pkg::CMD_CHIP_ERASE);
        push_req(1'b0, 16'hFFFF, 8'h00);
        wait_drained();

        // directed, 128 KB part: identification, bank select, program in bank 1
        set_part(1'b1);
        send_cmd(fsmc_pkg::CMD_ID_ENTER);
        push_req(1'b0, 16'h0000, 8'h00);
        push_req(1'b0, 16'h0001, 8'h00);
        send_cmd(fsmc_pkg::CMD_BANK);
        push_req(1'b1, 16'h0000, 8'h01);
        send_cmd(fsmc_pkg::CMD_PROGRAM);
        push_req(1'b1, fsmc_pkg::ADDR_UNLOCK1, 8'h3C);
        push_req(1'b0, fsmc_pkg::ADDR_UNLOCK1, 8'h00);
        send_cmd(fsmc_pkg::CMD_ID_EXIT);
        push_req(1'b0, 16'h0000, 8'h00);
        wait_drained();

        // random phases across both part sizes and idling patterns
        gen_random(315);
        wait_drained();

        set_part(1'b0);
        set_idling(60, 0);
        gen_random(315);
        wait_drained();

        set_part(1'b1);
        set_idling(0, 60);
        hold_trig = ~hold_trig;
        gen_random(315);
        wait_drained();

        set_part(1'b0);
        set_idling(6, 6);
        gen_random(315);
        wait_drained();

        repeat (20) @(negedge i_clk);
        if (rdata_expect.size() != 0)
            report_mismatch($sformatf("%0d reads never answered", rdata_expect.size()));
        if (err_cnt == 0)
            $display("PASS flash_save_memory_command_fsm");
        else
            $display("FAIL flash_save_memory_command_fsm");
        $finish;
    end

endmodule
